// ===== rtl/ogg_pkg.sv =====
package ogg_pkg;

    localparam int MAX_STREAMS  = 16;
    localparam int STREAM_W     = 4;
    localparam int MAX_SEGMENTS = 256;
    localparam int SEG_W        = 8;

    localparam logic [4:0] POS_COUNT   = 5'd26;
    localparam logic [4:0] POS_TABLE   = 5'd27;
    localparam logic [4:0] POS_PAYLOAD = 5'd28;
    localparam logic [4:0] POS_SER_LO  = 5'd14;
    localparam logic [4:0] POS_SER_HI  = 5'd17;
    localparam logic [4:0] POS_MAGIC   = 5'd5;

    localparam logic [3:0] CODEC_OK  = 4'd7;
    localparam logic [3:0] CODEC_BAD = 4'd8;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_CODEC   = 3'd2;
    localparam logic [2:0] ERR_ORDER   = 3'd3;
    localparam logic [2:0] ERR_STREAMS = 3'd4;

    localparam logic [7:0] LACE_FULL = 8'd255;

    // One compacted lacing entry: a nonzero lacing value and the zero
    // lacing values that follow it.
    typedef struct packed {
        logic [7:0] clos;
        logic [7:0] lace;
    } lace_entry_t;

    function automatic logic [7:0] page_magic(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h4F;
            3'd1:    v = 8'h67;
            3'd2:    v = 8'h67;
            3'd3:    v = 8'h53;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] vorbis_magic(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h01;
            3'd1:    v = 8'h76;
            3'd2:    v = 8'h6F;
            3'd3:    v = 8'h72;
            3'd4:    v = 8'h62;
            3'd5:    v = 8'h69;
            3'd6:    v = 8'h73;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ogg_if.sv =====
interface ogg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface ogg_res_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] payload_byte;
    logic [3:0] stream_index;
    logic       packet_end;
    logic [7:0] closures_after;
    logic       headers_done;
    logic [2:0] status;

    modport source (output valid, output data_valid, output payload_byte,
                    output stream_index, output packet_end, output closures_after,
                    output headers_done, output status, input ready);
    modport sink (input valid, input data_valid, input payload_byte,
                  input stream_index, input packet_end, input closures_after,
                  input headers_done, input status, output ready);
endinterface

// ===== rtl/ogg_lace_mem.sv =====
module ogg_lace_mem (
    input  logic                 clk,
    input  logic                 we,
    input  logic [7:0]           waddr,
    input  ogg_pkg::lace_entry_t wdata,
    input  logic [7:0]           raddr,
    output ogg_pkg::lace_entry_t rdata
);
    import ogg_pkg::*;

    lace_entry_t mem [MAX_SEGMENTS];
    lace_entry_t rdata_reg;

    // Write one entry; read with write-through on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ogg_page_deframer.sv =====
// Ogg page deframer: takes one file byte per cycle unless results stall,
// with a single output register between the byte channel and the result
// channel. Page headers are checked and parsed in place; the lacing table
// is compacted into a 256-entry memory (nonzero lacing values with the
// count of zero values after each), and the entry after the current one
// is prefetched so that back-to-back one-byte segments keep the full
// rate. Payload bytes come out tagged with the stream index, the
// end-of-packet flag and the zero-size closures that follow them. Header
// and lacing bytes give no result, except one carrying leading zero
// closures at the end of the lacing table. Once status is nonzero, every
// byte gives one result with that status and no other content.
module ogg_page_deframer (
    input logic   clk,
    input logic   rst_n,
    ogg_byte_if.sink  bytes,
    ogg_res_if.source results
);
    import ogg_pkg::*;

    typedef enum logic [1:0] {PH_FIRST, PH_WAIT, PH_DATA} phase_t;

    // Page parse state
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] serial_reg, serial_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  cursor_reg, cursor_next;
    logic [7:0]  lead_reg, lead_next;
    logic        have_any_reg, have_any_next;
    logic [7:0]  last_reg, last_next;
    lace_entry_t e0_reg, e0_next;
    lace_entry_t pend_reg, pend_next;
    logic [7:0]  cur_idx_reg, cur_idx_next;
    lace_entry_t cur_reg, cur_next;
    logic [7:0]  left_reg, left_next;
    logic [MAX_STREAMS-1:0] match_reg, match_next;
    logic        productive_reg, productive_next;

    // Stream state
    logic [31:0] serials_reg [MAX_STREAMS];
    logic [31:0] serials_next [MAX_STREAMS];
    logic [3:0]  codec_reg [MAX_STREAMS];
    logic [3:0]  codec_next [MAX_STREAMS];
    logic [STREAM_W:0]   known_reg, known_next;
    logic [STREAM_W-1:0] stream_reg, stream_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  err_reg, err_next;

    // Result register
    logic        out_valid_reg;
    logic        o_dv_reg, o_pend_reg, o_hdone_reg;
    logic [7:0]  o_byte_reg, o_clos_reg;
    logic [3:0]  o_stream_reg;
    logic [2:0]  o_status_reg;

    logic        emit, o_dv, o_pend, o_hdone;
    logic [7:0]  o_byte, o_clos;

    logic        accept;
    logic        mem_we;
    lace_entry_t mem_rdata, nxt;
    logic [7:0]  mem_raddr;

    assign bytes.ready = !out_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;

    // Entry after the current one: last entry lives in pend_reg
    assign nxt = ((cur_idx_reg + 8'd1) == last_reg) ? pend_reg : mem_rdata;
    assign mem_raddr = (accept ? cur_idx_next : cur_idx_reg) + 8'd1;

    ogg_lace_mem u_lace_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (last_reg),
        .wdata (pend_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    function automatic logic [7:0] serial_byte(input logic [31:0] s, input logic [1:0] k);
        logic [7:0] v;
        unique case (k)
            2'd0:    v = s[31:24];
            2'd1:    v = s[23:16];
            2'd2:    v = s[15:8];
            default: v = s[7:0];
        endcase
        return v;
    endfunction

    always_comb
    begin
        logic [7:0]             b;
        logic [3:0]             p;
        logic                   do_feed;
        logic                   do_close;
        logic                   end_pg;
        logic                   closing;
        logic                   bad;
        logic [MAX_STREAMS-1:0] hit;
        logic [STREAM_W-1:0]    hit_idx;
        logic [1:0]             k;
        logic [7:0]             left_dec;
        logic [3:0]             prog;

        b        = bytes.in_byte;
        p        = codec_reg[stream_reg];
        do_feed  = 1'b0;
        do_close = 1'b0;
        end_pg   = 1'b0;
        closing  = 1'b0;
        bad      = 1'b0;
        hit      = '0;
        hit_idx  = '0;
        k        = 2'(pos_reg - POS_SER_LO);
        left_dec = left_reg - 8'd1;
        prog     = '0;

        pos_next        = pos_reg;
        serial_next     = serial_reg;
        total_next      = total_reg;
        cursor_next     = cursor_reg;
        lead_next       = lead_reg;
        have_any_next   = have_any_reg;
        last_next       = last_reg;
        e0_next         = e0_reg;
        pend_next       = pend_reg;
        cur_idx_next    = cur_idx_reg;
        cur_next        = cur_reg;
        left_next       = left_reg;
        match_next      = match_reg;
        productive_next = productive_reg;
        serials_next    = serials_reg;
        codec_next      = codec_reg;
        known_next      = known_reg;
        stream_next     = stream_reg;
        phase_next      = phase_reg;
        err_next        = err_reg;
        mem_we          = 1'b0;

        emit    = 1'b0;
        o_dv    = 1'b0;
        o_byte  = '0;
        o_pend  = 1'b0;
        o_clos  = '0;
        o_hdone = 1'b0;

        if (err_reg != ERR_NONE)
        begin
            emit = 1'b1;
        end
        else if (pos_reg < POS_TABLE)
        begin
            // Page header
            if ((pos_reg < POS_MAGIC) && (b != page_magic(pos_reg[2:0])))
            begin
                err_next = ERR_MAGIC;
                emit     = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
                if ((pos_reg >= POS_SER_LO) && (pos_reg <= POS_SER_HI))
                begin
                    serial_next = {serial_reg[23:0], b};
                    for (int i = 0; i < MAX_STREAMS; i++)
                    begin
                        match_next[i] = ((pos_reg == POS_SER_LO) || match_reg[i])
                                        && (b == serial_byte(serials_reg[i], k));
                    end
                end
                if (pos_reg == POS_SER_HI)
                begin
                    for (int i = 0; i < MAX_STREAMS; i++)
                    begin
                        hit[i] = match_next[i] && ((STREAM_W+1)'(i) < known_reg);
                    end
                    for (int i = MAX_STREAMS - 1; i >= 0; i--)
                    begin
                        if (hit[i])
                        begin
                            hit_idx = STREAM_W'(i);
                        end
                    end
                    priority if (hit != '0)
                    begin
                        stream_next = hit_idx;
                    end
                    else if (known_reg >= (STREAM_W+1)'(MAX_STREAMS))
                    begin
                        err_next = ERR_STREAMS;
                        emit     = 1'b1;
                    end
                    else if (phase_reg == PH_DATA)
                    begin
                        err_next = ERR_ORDER;
                        emit     = 1'b1;
                    end
                    else
                    begin
                        serials_next[known_reg[STREAM_W-1:0]] = serial_next;
                        codec_next[known_reg[STREAM_W-1:0]]   = '0;
                        known_next  = known_reg + 1'b1;
                        stream_next = known_reg[STREAM_W-1:0];
                    end
                end
                if (pos_reg == POS_COUNT)
                begin
                    total_next      = b;
                    cursor_next     = '0;
                    lead_next       = '0;
                    productive_next = 1'b0;
                    have_any_next   = 1'b0;
                    if (b == 8'd0)
                    begin
                        end_pg = 1'b1;
                    end
                    else
                    begin
                        pos_next = POS_TABLE;
                    end
                end
            end
        end
        else if (pos_reg == POS_TABLE)
        begin
            // Lacing table: compact nonzero values, fold zeros into counts
            cursor_next = cursor_reg + 8'd1;
            if (b != LACE_FULL)
            begin
                productive_next = 1'b1;
            end
            if (b == 8'd0)
            begin
                priority if (!have_any_reg)
                begin
                    lead_next = lead_reg + 8'd1;
                end
                else if (last_reg == 8'd0)
                begin
                    e0_next.clos = e0_reg.clos + 8'd1;
                end
                else
                begin
                    pend_next.clos = pend_reg.clos + 8'd1;
                end
            end
            else if (!have_any_reg)
            begin
                e0_next       = '{clos: 8'd0, lace: b};
                last_next     = '0;
                have_any_next = 1'b1;
            end
            else
            begin
                mem_we    = accept && (last_reg != 8'd0);
                pend_next = '{clos: 8'd0, lace: b};
                last_next = last_reg + 8'd1;
            end
            if (cursor_next == total_reg)
            begin
                closing = productive_next && (phase_reg == PH_WAIT) && (stream_reg == '0);
                do_close = (lead_next != 8'd0);
                if (!have_any_next)
                begin
                    end_pg = 1'b1;
                end
                else
                begin
                    cur_idx_next = '0;
                    cur_next     = e0_next;
                    left_next    = e0_next.lace;
                    pos_next     = POS_PAYLOAD;
                end
                if (lead_next != 8'd0)
                begin
                    emit    = 1'b1;
                    o_clos  = lead_next;
                    o_hdone = closing;
                end
            end
        end
        else if (pos_reg == POS_PAYLOAD)
        begin
            // Payload byte
            closing   = productive_reg && (phase_reg == PH_WAIT) && (stream_reg == '0);
            do_feed   = 1'b1;
            left_next = left_dec;
            if (left_dec == 8'd0)
            begin
                o_pend   = (cur_reg.lace != LACE_FULL);
                o_clos   = cur_reg.clos;
                do_close = o_pend || (cur_reg.clos != 8'd0);
                if (cur_idx_reg == last_reg)
                begin
                    end_pg = 1'b1;
                end
                else
                begin
                    cur_idx_next = cur_idx_reg + 8'd1;
                    cur_next     = nxt;
                    left_next    = nxt.lace;
                end
            end
            emit    = 1'b1;
            o_dv    = 1'b1;
            o_byte  = b;
            o_hdone = closing;
        end
        else
        begin
            pos_next = '0;
        end

        // Advance the codec magic check of the current stream
        if (do_feed && (p < CODEC_OK))
        begin
            p = (b == vorbis_magic(p[2:0])) ? (p + 4'd1) : CODEC_BAD;
        end
        if (do_close && (p < CODEC_OK))
        begin
            p = CODEC_BAD;
        end
        if (do_feed || do_close)
        begin
            codec_next[stream_reg] = p;
        end

        // Close the page and step the header phase
        if (end_pg)
        begin
            pos_next = '0;
            if (productive_next)
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        phase_next = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        if (stream_reg == '0)
                        begin
                            for (int i = 0; i < MAX_STREAMS; i++)
                            begin
                                prog = (STREAM_W'(i) == stream_reg) ? p : codec_reg[i];
                                if (((STREAM_W+1)'(i) < known_reg) && (prog != CODEC_OK))
                                begin
                                    bad = 1'b1;
                                end
                            end
                            if (bad)
                            begin
                                err_next = ERR_CODEC;
                            end
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        phase_next = PH_DATA;
                    end
                    default:
                    begin
                        phase_next = PH_DATA;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            serial_reg     <= '0;
            total_reg      <= '0;
            cursor_reg     <= '0;
            lead_reg       <= '0;
            have_any_reg   <= 1'b0;
            last_reg       <= '0;
            cur_idx_reg    <= '0;
            left_reg       <= '0;
            match_reg      <= '0;
            productive_reg <= 1'b0;
            known_reg      <= '0;
            stream_reg     <= '0;
            phase_reg      <= PH_FIRST;
            err_reg        <= ERR_NONE;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                codec_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                pos_reg        <= pos_next;
                serial_reg     <= serial_next;
                total_reg      <= total_next;
                cursor_reg     <= cursor_next;
                lead_reg       <= lead_next;
                have_any_reg   <= have_any_next;
                last_reg       <= last_next;
                cur_idx_reg    <= cur_idx_next;
                left_reg       <= left_next;
                match_reg      <= match_next;
                productive_reg <= productive_next;
                known_reg      <= known_next;
                stream_reg     <= stream_next;
                phase_reg      <= phase_next;
                err_reg        <= err_next;
                codec_reg      <= codec_next;
                out_valid_reg  <= emit;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e0_reg       <= e0_next;
            pend_reg     <= pend_next;
            cur_reg      <= cur_next;
            serials_reg  <= serials_next;
            o_dv_reg     <= o_dv;
            o_byte_reg   <= o_byte;
            o_stream_reg <= (emit && (err_next == ERR_NONE || o_hdone || o_dv))
                            && (err_reg == ERR_NONE) && (pos_reg >= POS_TABLE)
                            ? stream_reg : '0;
            o_pend_reg   <= o_pend;
            o_clos_reg   <= o_clos;
            o_hdone_reg  <= o_hdone;
            o_status_reg <= err_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.data_valid     = o_dv_reg;
    assign results.payload_byte   = o_byte_reg;
    assign results.stream_index   = o_stream_reg;
    assign results.packet_end     = o_pend_reg;
    assign results.closures_after = o_clos_reg;
    assign results.headers_done   = o_hdone_reg;
    assign results.status         = o_status_reg;

`ifndef NO_ASSERTIONS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |=> (err_reg == $past(err_reg)))
        else $error("error code changed after being set");

    a_phase_final: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |=> (phase_reg == PH_DATA))
        else $error("header phase left the data state");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_PAYLOAD) |-> (left_reg != 8'd0))
        else $error("payload position with empty segment");

    a_known_bound: assert property (@(posedge clk) disable iff (!rst_n)
        known_reg <= (STREAM_W+1)'(MAX_STREAMS))
        else $error("stream count above table size");
`endif

endmodule
